// File: rtl/core/tdp_pkg.sv
// Shared constants and types for the trial-division prime test.
package tdp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam value_t FIRST_DIVISOR = value_t'(3);
  localparam value_t DIVISOR_STEP  = value_t'(2);
  localparam value_t SMALLEST_PRIME = value_t'(2);

endpackage

// File: rtl/core/tdp_divider.sv
// Radix-2 restoring divider that yields one quotient bit per cycle.
module tdp_divider
  import tdp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  value_t dividend,
  input  value_t divisor,
  output logic   done,
  output value_t quotient,
  output value_t remainder
);

  logic   busy_r, busy_nxt;
  logic   done_r, done_nxt;
  cnt_t   cnt_r, cnt_nxt;
  value_t quo_r, quo_nxt;
  value_t rem_r, rem_nxt;
  value_t den_r, den_nxt;

  logic [VALUE_BITS:0] rem_shift;
  logic [VALUE_BITS:0] rem_diff;
  logic                fits;

  // The dividend shifts out of the top of quo_r while quotient bits shift in below.
  assign rem_shift = {rem_r, quo_r[VALUE_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, den_r};
  assign fits      = (rem_shift >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[VALUE_BITS-2:0], fits};
      rem_nxt = fits ? rem_diff[VALUE_BITS-1:0] : rem_shift[VALUE_BITS-1:0];
      cnt_nxt = cnt_r + cnt_t'(1);
      if (cnt_r == cnt_t'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: rtl/core/trial_division_prime_test.sv
// Top level of the trial-division prime test: sequencer and result register.
//
// One candidate is tested at a time. Zero, one, two and even candidates are
// settled without the divider. An odd candidate is divided by 3, 5, 7, ...
// on a bit-serial divider, one trial divisor after another, and the search
// ends once the divisor exceeds the quotient or divides evenly, so a prime
// near 2**VALUE_BITS takes about 2**(VALUE_BITS/2 - 1) trial divisors.
// in_stall rises once a candidate beat has been taken and stays high until
// its verdict has been loaded into the output register; the result then
// waits there for the receiver while the next candidate is taken, though
// that candidate's verdict is held in S_DONE until the register is free.
module trial_division_prime_test
  import tdp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  value_t in_candidate,
  output logic   out_valid,
  input  logic   out_stall,
  output value_t out_tested_value,
  output logic   out_is_prime
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  value_t cand_r, cand_nxt;
  value_t div_r, div_nxt;
  logic   verdict_r, verdict_nxt;
  logic   start_r, start_nxt;
  logic   out_valid_r, out_valid_nxt;
  value_t out_value_r, out_value_nxt;
  logic   out_prime_r, out_prime_nxt;

  logic   div_done;
  value_t div_quo;
  value_t div_rem;

  tdp_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (cand_r),
    .divisor   (div_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    div_nxt       = div_r;
    verdict_nxt   = verdict_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_prime_nxt = out_prime_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cand_nxt = in_candidate;
          if (in_candidate[VALUE_BITS-1:1] == '0) begin
            verdict_nxt = 1'b0;
            state_nxt   = S_DONE;
          end else if (in_candidate == SMALLEST_PRIME) begin
            verdict_nxt = 1'b1;
            state_nxt   = S_DONE;
          end else if (!in_candidate[0]) begin
            verdict_nxt = 1'b0;
            state_nxt   = S_DONE;
          end else begin
            div_nxt   = FIRST_DIVISOR;
            start_nxt = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          // Once the divisor passes the quotient, its square passes the candidate.
          if (div_r > div_quo) begin
            verdict_nxt = 1'b1;
            state_nxt   = S_DONE;
          end else if (div_rem == '0) begin
            verdict_nxt = 1'b0;
            state_nxt   = S_DONE;
          end else begin
            div_nxt   = div_r + DIVISOR_STEP;
            start_nxt = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = cand_r;
          out_prime_nxt = verdict_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cand_r      <= cand_nxt;
    div_r       <= div_nxt;
    verdict_r   <= verdict_nxt;
    out_value_r <= out_value_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_tested_value = out_value_r;
  assign out_is_prime     = out_prime_r;

endmodule

// File: rtl/core/tdp_checker.sv
// Port-level checks for the trial-division prime test, bound to the top level.
module tdp_checker
  import tdp_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_stall,
  input value_t in_candidate,
  input logic   out_valid,
  input logic   out_stall,
  input value_t out_tested_value,
  input logic   out_is_prime
);

  // A held result beat keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tested_value)
      && $stable(out_is_prime))
    else $error("stalled result beat changed");

  // Only one candidate is in flight: the input stalls after a beat is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a candidate beat");

  // Every prime reported is either two or odd.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_prime |-> out_tested_value == SMALLEST_PRIME
      || out_tested_value[0])
    else $error("even value other than two reported prime");

  // Zero and one are never prime.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tested_value[VALUE_BITS-1:1] == '0 |-> !out_is_prime)
    else $error("zero or one reported prime");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_candidate     (in_candidate),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_tested_value (out_tested_value),
  .out_is_prime     (out_is_prime)
);

// File: test/tb_top.sv
// Testbench for the trial-division prime test: directed and random candidates, self-checked.
`timescale 1ns / 100ps

module tb_top
  import tdp_pkg::*;
();

  localparam int unsigned RUN_LIMIT = 3_000_000;
  localparam int          TAIL_CYCLES = 50;

  typedef struct packed {
    value_t value;
    logic   prime;
  } verdict_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  value_t in_candidate = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  value_t out_tested_value;
  logic   out_is_prime;

  verdict_t    pending_verdicts[$];
  int          mismatches = 0;
  int          candidates_sent = 0;
  int          verdicts_checked = 0;
  int          primes_seen = 0;
  int unsigned cycle_count = 0;
  int          rx_hold = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;

  trial_division_prime_test dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_candidate     (in_candidate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tested_value (out_tested_value),
    .out_is_prime     (out_is_prime)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic logic predict_prime(value_t candidate);
    longint unsigned n;
    longint unsigned divisor;
    n = 64'(candidate);
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (divisor = 3; divisor <= n / divisor; divisor += 2) begin
      if (n % divisor == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // A full-width value with a factor of 2, 3 or 5, so the search stops by the second divisor.
  function automatic value_t pick_wide_candidate();
    value_t      c;
    int unsigned factor;
    c = $urandom;
    case ($urandom_range(0, 2))
      0: factor = 2;
      1: factor = 3;
      default: factor = 5;
    endcase
    if (factor == 2) begin
      c[0] = 1'b0;
    end else begin
      c = c - c % factor;
      if (c[0] == 1'b0 && c >= factor) c = c - factor;
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_candidate(value_t candidate);
    int gap;
    verdict_t verdict;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_candidate <= candidate;
    do @(posedge clk); while (in_stall);
    verdict.value = candidate;
    verdict.prime = predict_prime(candidate);
    pending_verdicts.push_back(verdict);
    candidates_sent++;
  endtask

  task automatic wait_for_verdicts();
    if (in_valid) in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) rx_hold--;
    else rx_hold = pick_gap(rx_quiet);
    out_stall <= (rx_hold > 0);
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_tested_value), 64'(0));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tested_value !== want.value)
          report_mismatch("tested_value", 64'(out_tested_value), 64'(want.value));
        if (out_is_prime !== want.prime)
          report_mismatch($sformatf("is_prime of %0d", want.value),
                          64'(out_is_prime), 64'(want.prime));
        verdicts_checked++;
        if (want.prime) primes_seen++;
      end
    end
  end

  // 0, 1, 2, 4, small primes, 15, and odd squares where the divisor just reaches the bound.
  task automatic test_small_values();
    value_t values[$];
    values = '{0, 1, 2, 3, 4, 5, 7, 9, 15, 25, 49, 97, 121};
    foreach (values[i]) send_candidate(values[i]);
  endtask

  task automatic test_wide_values();
    value_t values[$];
    values = '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
               32'hAAAA_AAAA, 32'h5555_5555, 65535, 65537};
    foreach (values[i]) send_candidate(values[i]);
  endtask

  // Products of two large close primes, and 16777213, keep the search running up to the bound.
  task automatic test_long_searches();
    send_candidate(value_t'(4091 * 4093));
    send_candidate(value_t'(4093 * 4093));
    send_candidate(value_t'(16777213));
  endtask

  task automatic test_back_to_back(int count);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (count) send_candidate(value_t'($urandom_range(0, 2047)));
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_random_mix(int count);
    int r;
    repeat (count) begin
      r = int'($urandom_range(0, 99));
      if (r < 55) send_candidate(value_t'($urandom_range(0, 4095)));
      else if (r < 80) send_candidate(value_t'($urandom_range(4096, 65535)));
      else send_candidate(pick_wide_candidate());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_small_values();
    test_wide_values();
    test_long_searches();
    // Hold the sender off until every verdict so far has been drained.
    wait_for_verdicts();
    test_back_to_back(15);
    test_random_mix(61);

    wait_for_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d candidates, from 0 and 1 up to full-width values and long searches.",
             candidates_sent);
    $display("Checked %0d verdicts, %0d of them prime, with %0d mismatches.",
             verdicts_checked, primes_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: trial_division_prime_test.f
rtl/core/tdp_pkg.sv
rtl/core/tdp_divider.sv
rtl/core/trial_division_prime_test.sv
rtl/core/tdp_checker.sv
test/tb_top.sv
